// File: design/mtl_pkg.sv
`timescale 1ns / 1ps

package mtl_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_FIRED   = 2'd0,
        KIND_ADDED   = 2'd1,
        KIND_FULL    = 2'd2,
        KIND_CLEARED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_FLUSH,
        S_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
        logic flush;
        logic resp;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic hit;
        logic pend_valid;
        logic out_free;
    } status_t;

endpackage

// File: design/mtl_datapath.sv
`timescale 1ns / 1ps

module mtl_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  mtl_pkg::cmd_t    cmd,
    output mtl_pkg::status_t status,
    input  logic [1:0]       mode,
    input  logic [15:0]      period,
    input  logic             periodic,
    input  logic [15:0]      tag,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       kind,
    output logic [15:0]      fired_tag,
    output logic             last
);
    import mtl_pkg::*;

    // timer store, one entry per slot
    logic [15:0] per_mem [SLOTS];
    logic [15:0] cnt_mem [SLOTS];
    logic        rst_mem [SLOTS];
    logic [15:0] tag_mem [SLOTS];

    mode_t            op_reg;
    logic [15:0]      per_in_reg;
    logic             prd_in_reg;
    logic [15:0]      tag_in_reg;

    logic [CNT_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] wr_reg, wr_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [15:0]      pend_tag_reg, pend_tag_next;
    logic             out_valid_reg, out_valid_next;
    kind_t            kind_reg, kind_next;
    logic [15:0]      tag_out_reg, tag_out_next;
    logic             last_reg, last_next;

    logic [IDX_W-1:0] rd_idx;
    logic [15:0]      cur_per, cur_cnt, cur_tag, cnt_inc, new_cnt;
    logic             cur_rst, hit, keep, full, out_free, do_add;

    assign rd_idx   = rd_reg[IDX_W-1:0];
    assign cur_per  = per_mem[rd_idx];
    assign cur_cnt  = cnt_mem[rd_idx];
    assign cur_rst  = rst_mem[rd_idx];
    assign cur_tag  = tag_mem[rd_idx];
    assign cnt_inc  = cur_cnt + 16'd1;
    assign full     = (occ_reg == SLOTS_CNT);
    assign out_free = !out_valid_reg || out_ready;
    assign do_add   = cmd.resp && (op_reg == MODE_ADD) && !full;

    always_comb
    begin
        if (cur_per == 16'd0)
        begin
            // never fires, count saturates
            hit     = 1'b0;
            new_cnt = (cur_cnt == 16'hFFFF) ? cur_cnt : cnt_inc;
        end
        else
        begin
            hit     = (cnt_inc == cur_per);
            new_cnt = hit ? 16'd0 : cnt_inc;
        end
        keep = !hit || cur_rst;
    end

    always_comb
    begin
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        occ_next        = occ_reg;
        pend_valid_next = pend_valid_reg;
        pend_tag_next   = pend_tag_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;
        kind_next       = kind_reg;
        tag_out_next    = tag_out_reg;
        last_next       = last_reg;

        if (cmd.load)
        begin
            rd_next         = '0;
            wr_next         = '0;
            pend_valid_next = 1'b0;
        end

        if (cmd.scan)
        begin
            rd_next = rd_reg + CNT_W'(1);
            if (keep)
                wr_next = wr_reg + CNT_W'(1);
            if (hit)
            begin
                // an earlier fired word goes out now, it is not the last one
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_FIRED;
                    tag_out_next   = pend_tag_reg;
                    last_next      = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_tag_next   = cur_tag;
            end
        end

        if (cmd.commit)
            occ_next = wr_reg;

        if (cmd.flush)
        begin
            out_valid_next  = 1'b1;
            kind_next       = KIND_FIRED;
            tag_out_next    = pend_tag_reg;
            last_next       = 1'b1;
            pend_valid_next = 1'b0;
        end

        if (cmd.resp)
        begin
            out_valid_next = 1'b1;
            last_next      = 1'b1;
            case (op_reg)
                MODE_ADD:
                begin
                    kind_next    = full ? KIND_FULL : KIND_ADDED;
                    tag_out_next = tag_in_reg;
                    if (!full)
                        occ_next = occ_reg + CNT_W'(1);
                end
                default:
                begin
                    kind_next    = KIND_CLEARED;
                    tag_out_next = 16'd0;
                    occ_next     = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan && keep)
        begin
            per_mem[wr_reg[IDX_W-1:0]] <= cur_per;
            cnt_mem[wr_reg[IDX_W-1:0]] <= new_cnt;
            rst_mem[wr_reg[IDX_W-1:0]] <= cur_rst;
            tag_mem[wr_reg[IDX_W-1:0]] <= cur_tag;
        end
        else if (do_add)
        begin
            per_mem[occ_reg[IDX_W-1:0]] <= per_in_reg;
            cnt_mem[occ_reg[IDX_W-1:0]] <= 16'd0;
            rst_mem[occ_reg[IDX_W-1:0]] <= prd_in_reg;
            tag_mem[occ_reg[IDX_W-1:0]] <= tag_in_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= mode_t'(mode);
            per_in_reg <= period;
            prd_in_reg <= periodic;
            tag_in_reg <= tag;
        end
        pend_tag_reg <= pend_tag_next;
        kind_reg     <= kind_next;
        tag_out_reg  <= tag_out_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg         <= '0;
            wr_reg         <= '0;
            occ_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_reg         <= rd_next;
            wr_reg         <= wr_next;
            occ_reg        <= occ_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign status.scan_done  = (rd_reg == occ_reg);
    assign status.hit        = hit;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign fired_tag = tag_out_reg;
    assign last      = last_reg;

endmodule

// File: design/mtl_ctrl.sv
`timescale 1ns / 1ps

module mtl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       mode,
    input  mtl_pkg::status_t status,
    output mtl_pkg::cmd_t    cmd
);
    import mtl_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode_t'(mode))
                        MODE_TICK:  state_next = S_TICK;
                        MODE_ADD:   state_next = S_RESP;
                        MODE_CLEAR: state_next = S_RESP;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_TICK:
            begin
                if (status.scan_done)
                    state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (!status.pend_valid || status.out_free)
                    state_next = S_IDLE;
            end
            S_RESP:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        cmd.load   = (state_reg == S_IDLE) && in_valid;
        // a hit with a word already pending needs room at the output
        cmd.scan   = (state_reg == S_TICK) && !status.scan_done &&
                     (!status.hit || !status.pend_valid || status.out_free);
        cmd.commit = (state_reg == S_TICK) && status.scan_done;
        cmd.flush  = (state_reg == S_FLUSH) && status.pend_valid && status.out_free;
        cmd.resp   = (state_reg == S_RESP) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: design/multi_timer_list.sv
// add and clear: one word out once the output is free, then the next input word is taken
// tick: the scan walks the store, then the flush puts out the last fired word, if any, and the next input word is taken
// the scan and the flush wait while a fired word is held up by a stalled output
// tick walks one entry per cycle unless a hit waits on a stalled output, so throughput follows occupancy
// an input word is taken while the previous result still sits in the output register
// asynchronous active-low reset empties the bank and drops any pending output word
`timescale 1ns / 1ps

module multi_timer_list (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] period,
    input  logic        periodic,
    input  logic [15:0] tag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] fired_tag,
    output logic        last
);
    import mtl_pkg::*;

    cmd_t    cmd;
    status_t status;

    mtl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .status   (status),
        .cmd      (cmd)
    );

    mtl_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .mode      (mode),
        .period    (period),
        .periodic  (periodic),
        .tag       (tag),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .fired_tag (fired_tag),
        .last      (last)
    );

endmodule

// File: design/mtl_checker.sv
`timescale 1ns / 1ps

module mtl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  mode,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [15:0] fired_tag,
    input logic        last
);
    import mtl_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(fired_tag)
            && $stable(last))
        else $error("output word changed while stalled");

    a_clear_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_CLEARED |-> fired_tag == 16'd0 && last)
        else $error("clear word malformed");

    a_add_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ADDED || kind == KIND_FULL) |-> last)
        else $error("add result not marked last");

    // any meaningful word leaves the block busy in the cycle after it is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode != MODE_NONE |=> !in_ready)
        else $error("input taken again while busy");

endmodule

bind multi_timer_list mtl_checker u_mtl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .fired_tag (fired_tag),
    .last      (last)
);
